/* hdl/subswath_stitch_phase_correct_unit_defines.svh */
// assertion macros shared by the subswath stitch rtl
`ifndef SUBSWATH_STITCH_PHASE_CORRECT_UNIT_DEFINES_SVH
`define SUBSWATH_STITCH_PHASE_CORRECT_UNIT_DEFINES_SVH

// same-cycle implication, clocked on i_clk, quiet while i_rst_n is low
`define SSPC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sspc assertion failed");

// next-cycle implication, clocked on i_clk, quiet while i_rst_n is low
`define SSPC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sspc assertion failed");

`endif

/* hdl/sspc_pkg.sv */
// shared types, constants and the sine table generator of the subswath stitch unit
`default_nettype none

package sspc_pkg;

    localparam int NUM_SUBSWATHS   = 3;
    localparam int MAX_WIDTH       = 32768;
    localparam int DEF_QUEUE_DEPTH = 4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int COL_W       = 15;
    localparam int DEST_W      = 17;
    localparam int SAMPLE_W    = 16;
    localparam int TRIM_W      = 12;
    localparam int WREG_W      = 16;
    localparam int WIDTH_W     = 17;
    localparam int ANGLE_W     = 32;
    localparam int QSIN_W      = 15;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_COMPLEX_MODE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OVERLAP_TRIM = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_WIDTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SECOND_WIDTH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_ONE   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_TWO   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOPE_ONE    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOPE_TWO    = 3'd7;

    localparam logic [TRIM_W-1:0] TRIM_RESET  = 12'd50;
    localparam logic [WREG_W-1:0] WIDTH_RESET = 16'd32768;

    localparam logic [63:0] PI_Q60   = 64'h3243_F6A8_885A_308D;
    localparam logic [63:0] LOW_MASK = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]                 subswath;
        logic [COL_W-1:0]           source_column;
        logic signed [SAMPLE_W-1:0] sample_re;
        logic signed [SAMPLE_W-1:0] sample_im;
    } t_in;

    typedef struct packed {
        logic [DEST_W-1:0]          dest_column;
        logic signed [SAMPLE_W-1:0] result_re;
        logic signed [SAMPLE_W-1:0] result_im;
    } t_out;

    typedef struct packed {
        logic                      complex_mode;
        logic [TRIM_W-1:0]         overlap_trim;
        logic [WREG_W-1:0]         first_width;
        logic [WREG_W-1:0]         second_width;
        logic [ANGLE_W-1:0]        offset_one;
        logic [ANGLE_W-1:0]        offset_two;
        logic signed [ANGLE_W-1:0] slope_one;
        logic signed [ANGLE_W-1:0] slope_two;
    } t_cfg;

    // kept pixel as it sits in the queue
    typedef struct packed {
        logic [1:0]                 subswath;
        logic [COL_W-1:0]           source_column;
        logic [DEST_W-1:0]          dest_column;
        logic signed [SAMPLE_W-1:0] sample_re;
        logic signed [SAMPLE_W-1:0] sample_im;
    } t_item;

    typedef struct packed {
        logic has_room;
        logic has_data;
    } t_q_stat;

    // (a * b) >> 60 from 32-bit partial products
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] al, ah, bl, bh, lo, m1, m2, hi, mid, high, low;
        al   = a & LOW_MASK;
        ah   = a >> 32;
        bl   = b & LOW_MASK;
        bh   = b >> 32;
        lo   = al * bl;
        m1   = ah * bl;
        m2   = al * bh;
        hi   = ah * bh;
        mid  = (lo >> 32) + (m1 & LOW_MASK) + (m2 & LOW_MASK);
        high = hi + (m1 >> 32) + (m2 >> 32) + (mid >> 32);
        low  = (mid << 32) | (lo & LOW_MASK);
        return (high << 4) | (low >> 60);
    endfunction

    // quarter-wave sine entry k of 1024, unsigned q0.15 rounded, full scale clipped
    function automatic logic [QSIN_W-1:0] qsin_entry(input int k);
        logic [63:0] step, x, x2, term, acc, v;
        step = PI_Q60 >> 11;
        x    = step * 64'(k);
        x2   = mul_q60(x, x);
        term = x;
        acc  = x;
        term = mul_q60(term, x2) / 64'd6;   acc = acc - term;
        term = mul_q60(term, x2) / 64'd20;  acc = acc + term;
        term = mul_q60(term, x2) / 64'd42;  acc = acc - term;
        term = mul_q60(term, x2) / 64'd72;  acc = acc + term;
        term = mul_q60(term, x2) / 64'd110; acc = acc - term;
        term = mul_q60(term, x2) / 64'd156; acc = acc + term;
        term = mul_q60(term, x2) / 64'd210; acc = acc - term;
        term = mul_q60(term, x2) / 64'd272; acc = acc + term;
        term = mul_q60(term, x2) / 64'd342; acc = acc - term;
        term = mul_q60(term, x2) / 64'd420; acc = acc + term;
        term = mul_q60(term, x2) / 64'd506; acc = acc - term;
        term = mul_q60(term, x2) / 64'd600; acc = acc + term;
        term = mul_q60(term, x2) / 64'd702; acc = acc - term;
        term = mul_q60(term, x2) / 64'd812; acc = acc + term;
        v = (acc + 64'h0000_1000_0000_0000) >> 45;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[QSIN_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* hdl/sspc_front.sv */
// front end: takes pixels, drops trimmed columns, places kept ones in the merged row
`default_nettype none

module sspc_front
    import sspc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    input  wire t_in     i_data,
    input  wire t_cfg    i_cfg,
    input  wire t_q_stat i_q_stat,
    output logic         o_push,
    output t_item        o_item
);

    logic              r_f_valid;
    t_in               r_f;
    logic [DEST_W-1:0] r_base_one;
    logic [DEST_W-1:0] r_base_two;

    logic [WIDTH_W-1:0] w_first;
    logic [WIDTH_W-1:0] w_second;
    logic [WIDTH_W-1:0] w_trim;
    logic [WIDTH_W-1:0] w_trim2;
    logic [WIDTH_W-1:0] w_cnt_one;
    logic [WIDTH_W-1:0] w_cnt_two;
    logic [WIDTH_W:0]   w_col_ext;
    logic [WIDTH_W:0]   w_trim_ext;
    logic [WIDTH_W:0]   w_width_sel;
    logic               w_known;
    logic               w_head_drop;
    logic               w_tail_cut;
    logic               w_tail_drop;
    logic               w_keep;
    logic               w_leave;
    logic               w_accept;
    logic [DEST_W-1:0]  w_base;
    logic [DEST_W-1:0]  w_shift;
    logic               n_f_valid;

    // saturated widths and kept counts of the leading subswaths
    assign w_first   = ({1'b0, i_cfg.first_width} > WIDTH_W'(MAX_WIDTH))
                     ? WIDTH_W'(MAX_WIDTH) : {1'b0, i_cfg.first_width};
    assign w_second  = ({1'b0, i_cfg.second_width} > WIDTH_W'(MAX_WIDTH))
                     ? WIDTH_W'(MAX_WIDTH) : {1'b0, i_cfg.second_width};
    assign w_trim    = {{(WIDTH_W-TRIM_W){1'b0}}, i_cfg.overlap_trim};
    assign w_trim2   = {{(WIDTH_W-TRIM_W-1){1'b0}}, i_cfg.overlap_trim, 1'b0};
    assign w_cnt_one = (w_first > w_trim) ? (w_first - w_trim) : '0;
    assign w_cnt_two = (w_second > w_trim2) ? (w_second - w_trim2) : '0;

    always_ff @(posedge i_clk) begin
        r_base_one <= DEST_W'(w_cnt_one);
        r_base_two <= DEST_W'(w_cnt_one + w_cnt_two);
    end

    // classification of the held pixel
    assign w_col_ext   = {{(WIDTH_W+1-COL_W){1'b0}}, r_f.source_column};
    assign w_trim_ext  = {1'b0, w_trim};
    assign w_width_sel = (r_f.subswath == 2'd0) ? {1'b0, w_first} : {1'b0, w_second};
    assign w_known     = (int'(r_f.subswath) < NUM_SUBSWATHS);
    assign w_head_drop = (r_f.subswath != 2'd0) && (w_col_ext < w_trim_ext);
    assign w_tail_cut  = (r_f.subswath == 2'd0)
                      || ((r_f.subswath == 2'd1) && (NUM_SUBSWATHS > 2));
    assign w_tail_drop = w_tail_cut && ((w_col_ext + w_trim_ext) >= w_width_sel);
    assign w_keep      = w_known && !w_head_drop && !w_tail_drop;

    always_comb begin
        case (r_f.subswath)
            2'd0:    w_base = '0;
            2'd1:    w_base = r_base_one;
            default: w_base = r_base_two;
        endcase
    end

    assign w_shift = (r_f.subswath != 2'd0) ? DEST_W'(w_trim) : '0;

    assign w_leave  = r_f_valid && (!w_keep || i_q_stat.has_room);
    assign o_stall  = r_f_valid && !w_leave;
    assign w_accept = i_valid && !o_stall;
    assign o_push   = r_f_valid && w_keep && i_q_stat.has_room;

    assign o_item.subswath      = r_f.subswath;
    assign o_item.source_column = r_f.source_column;
    assign o_item.dest_column   = w_base + {{(DEST_W-COL_W){1'b0}}, r_f.source_column} - w_shift;
    assign o_item.sample_re     = r_f.sample_re;
    assign o_item.sample_im     = r_f.sample_im;

    assign n_f_valid = w_accept ? 1'b1 : (w_leave ? 1'b0 : r_f_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else begin
            r_f_valid <= n_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_f <= i_data;
        end
    end

endmodule

`default_nettype wire

/* hdl/sspc_queue.sv */
// short queue of kept pixels between front and back
`default_nettype none
`include "subswath_stitch_phase_correct_unit_defines.svh"

module sspc_queue
    import sspc_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output t_item      o_item,
    output t_q_stat    o_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(DEPTH - 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_item          = r_mem[r_rptr];
    assign o_stat.has_room = (r_count != FULL_COUNT);
    assign o_stat.has_data = (r_count != '0);

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    `SSPC_ASSERT_IMP(a_no_overflow, i_push, r_count != FULL_COUNT)
    `SSPC_ASSERT_IMP(a_no_underflow, i_pop, r_count != '0)
    `SSPC_ASSERT_NXT(a_count_steady, i_push == i_pop, $stable(r_count))

endmodule

`default_nettype wire

/* hdl/sspc_back.sv */
// back end: angle ramp, sine/cosine lookup, rotation or phase subtract, output register
`default_nettype none

module sspc_back
    import sspc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cfg    i_cfg,
    input  wire t_q_stat i_q_stat,
    output logic         o_pop,
    input  wire t_item   i_item,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_out         o_data
);

    localparam logic [QSIN_W-1:0] QSIN_TOP = qsin_entry(1024);

    // quarter-wave table, four banks of 256
    logic [QSIN_W-1:0] w_qsin [4][256];

    for (genvar q = 0; q < 4; q++) begin : g_bank
        for (genvar j = 0; j < 256; j++) begin : g_ent
            localparam logic [QSIN_W-1:0] QSIN_VAL = qsin_entry(q * 256 + j);
            assign w_qsin[q][j] = QSIN_VAL;
        end
    end

    logic w_en;

    logic r_a_valid, r_b_valid, r_c_valid, r_d_valid, r_e_valid, r_f_valid, r_g_valid;
    t_item r_a_item, r_b_item, r_c_item, r_d_item, r_e_item, r_f_item;

    logic [ANGLE_W-1:0]  r_b_prod;
    logic [ANGLE_W-1:0]  r_c_angle;
    logic [QSIN_W-1:0]   r_d_part [2][4];
    logic [1:0]          r_d_sel  [2];
    logic                r_d_top  [2];
    logic                r_d_neg  [2];
    logic [SAMPLE_W-1:0] r_d_phase, r_e_phase, r_f_phase;
    logic signed [SAMPLE_W-1:0] r_e_trig [2];
    logic signed [31:0]  r_f_rc, r_f_is, r_f_ic, r_f_rs;
    t_out                r_g_data;

    logic [ANGLE_W-1:0]  w_slope;
    logic [46:0]         w_prod;
    logic [ANGLE_W-1:0]  w_offset;
    logic [11:0]         w_idx   [2];
    logic [10:0]         w_tix   [2];
    logic [SAMPLE_W-1:0] w_a16;
    logic [QSIN_W-1:0]   w_mag   [2];
    logic signed [32:0]  w_acc_re, w_acc_im;
    logic signed [32:0]  w_rnd_re, w_rnd_im;
    t_out                w_out;

    function automatic logic [SAMPLE_W-1:0] sat16(input logic signed [17:0] v);
        logic [SAMPLE_W-1:0] res;
        if (v > 18'sd32767) begin
            res = 16'h7FFF;
        end else if (v < -18'sd32768) begin
            res = 16'h8000;
        end else begin
            res = v[SAMPLE_W-1:0];
        end
        return res;
    endfunction

    // whole pipe advances unless a finished result is held
    assign w_en  = !r_g_valid || !i_stall;
    assign o_pop = i_q_stat.has_data && w_en;

    // ramp product
    always_comb begin
        case (r_a_item.subswath)
            2'd1:    w_slope = i_cfg.slope_one;
            2'd2:    w_slope = i_cfg.slope_two;
            default: w_slope = '0;
        endcase
    end
    assign w_prod = {15'b0, w_slope} * {32'b0, r_a_item.source_column};

    always_comb begin
        case (r_b_item.subswath)
            2'd1:    w_offset = i_cfg.offset_one;
            2'd2:    w_offset = i_cfg.offset_two;
            default: w_offset = '0;
        endcase
    end

    // sine at index 0, cosine at index 1
    assign w_idx[0] = r_c_angle[ANGLE_W-1 -: 12];
    assign w_idx[1] = r_c_angle[ANGLE_W-1 -: 12] + 12'd1024;
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            w_tix[i] = w_idx[i][10] ? (11'd1024 - {1'b0, w_idx[i][9:0]})
                                    : {1'b0, w_idx[i][9:0]};
        end
    end
    assign w_a16 = SAMPLE_W'((r_c_angle + 32'h0000_8000) >> 16);

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            w_mag[i] = r_d_top[i] ? QSIN_TOP : r_d_part[i][r_d_sel[i]];
        end
    end

    // rounded and clipped rotation sums
    assign w_acc_re = 33'(r_f_rc) + 33'(r_f_is);
    assign w_acc_im = 33'(r_f_ic) - 33'(r_f_rs);
    assign w_rnd_re = w_acc_re + 33'sd16384;
    assign w_rnd_im = w_acc_im + 33'sd16384;

    always_comb begin
        w_out.dest_column = r_f_item.dest_column;
        if (i_cfg.complex_mode) begin
            w_out.result_re = sat16(w_rnd_re[32:15]);
            w_out.result_im = sat16(w_rnd_im[32:15]);
        end else begin
            w_out.result_re = r_f_phase;
            w_out.result_im = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
            r_g_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= o_pop;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
            r_f_valid <= r_e_valid;
            r_g_valid <= r_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_item  <= i_item;
            r_b_item  <= r_a_item;
            r_b_prod  <= w_prod[ANGLE_W-1:0];
            r_c_item  <= r_b_item;
            r_c_angle <= w_offset + r_b_prod;
            r_d_item  <= r_c_item;
            r_d_phase <= r_c_item.sample_re - w_a16;
            for (int i = 0; i < 2; i++) begin
                for (int q = 0; q < 4; q++) begin
                    r_d_part[i][q] <= w_qsin[q][w_tix[i][7:0]];
                end
                r_d_sel[i] <= w_tix[i][9:8];
                r_d_top[i] <= w_tix[i][10];
                r_d_neg[i] <= w_idx[i][11];
            end
            r_e_item  <= r_d_item;
            r_e_phase <= r_d_phase;
            for (int i = 0; i < 2; i++) begin
                r_e_trig[i] <= r_d_neg[i] ? -$signed({1'b0, w_mag[i]})
                                          : $signed({1'b0, w_mag[i]});
            end
            r_f_item  <= r_e_item;
            r_f_phase <= r_e_phase;
            r_f_rc    <= 32'(r_e_item.sample_re) * 32'(r_e_trig[1]);
            r_f_is    <= 32'(r_e_item.sample_im) * 32'(r_e_trig[0]);
            r_f_ic    <= 32'(r_e_item.sample_im) * 32'(r_e_trig[1]);
            r_f_rs    <= 32'(r_e_item.sample_re) * 32'(r_e_trig[0]);
            r_g_data  <= w_out;
        end
    end

    assign o_valid = r_g_valid;
    assign o_data  = r_g_data;

endmodule

`default_nettype wire

/* hdl/subswath_stitch_phase_correct_unit.sv */
// top level of the subswath stitch and phase-ramp correction unit
`default_nettype none

// Stitches pixels of up to three subswaths into one merged row and removes
// each subswath's phase ramp. A pixel arrives tagged with its subswath and
// source column; columns inside the trimmed overlap band of a seam are
// dropped, every other pixel leaves with its merged-row column and a sample
// that is either the wrapped phase minus the ramp angle (phase mode) or the
// complex sample rotated by minus the ramp angle (complex mode). Sustained
// rate is one pixel per clock on both sides, dropped pixels included, when
// the output does not stall. A kept pixel passes the front register, the
// queue and seven back-end stages (queue read, ramp multiply, angle add,
// sine/cosine bank read, sign and quadrant fix, four 16x16 products,
// round/clip into the output register). The queue between front and back
// holds QUEUE_DEPTH pixels, so an output stall reaches the input only once
// the queue has filled. The user must write configuration through the plain
// write port only while the unit is empty; the unit does not enforce this.

module subswath_stitch_phase_correct_unit
    import sspc_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // pixel input
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire t_in                    i_data,
    // result output
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output t_out                        o_data,
    // configuration writes
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // configuration register file
    t_cfg r_cfg;

    // front to queue
    logic    w_push;
    t_item   w_push_item;
    // queue to back
    logic    w_pop;
    t_item   w_pop_item;
    t_q_stat w_q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.complex_mode <= 1'b0;
            r_cfg.overlap_trim <= TRIM_RESET;
            r_cfg.first_width  <= WIDTH_RESET;
            r_cfg.second_width <= WIDTH_RESET;
            r_cfg.offset_one   <= '0;
            r_cfg.offset_two   <= '0;
            r_cfg.slope_one    <= '0;
            r_cfg.slope_two    <= '0;
        end else if (i_cfg_we) begin
            // each register keeps the low bits of the written word
            case (i_cfg_index)
                REG_COMPLEX_MODE: r_cfg.complex_mode <= i_cfg_data[0];
                REG_OVERLAP_TRIM: r_cfg.overlap_trim <= i_cfg_data[TRIM_W-1:0];
                REG_FIRST_WIDTH:  r_cfg.first_width  <= i_cfg_data[WREG_W-1:0];
                REG_SECOND_WIDTH: r_cfg.second_width <= i_cfg_data[WREG_W-1:0];
                REG_OFFSET_ONE:   r_cfg.offset_one   <= i_cfg_data[ANGLE_W-1:0];
                REG_OFFSET_TWO:   r_cfg.offset_two   <= i_cfg_data[ANGLE_W-1:0];
                REG_SLOPE_ONE:    r_cfg.slope_one    <= i_cfg_data[ANGLE_W-1:0];
                REG_SLOPE_TWO:    r_cfg.slope_two    <= i_cfg_data[ANGLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front: input transfer, trim decision, merged-row column
    sspc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_data   (i_data),
        .i_cfg    (r_cfg),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_item   (w_push_item)
    );

    // decoupling queue, lets either side stall on its own
    sspc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_item  (w_pop_item),
        .o_stat  (w_q_stat)
    );

    // back: ramp angle, sine/cosine, rotation or phase subtract
    sspc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .i_item   (w_pop_item),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_data   (o_data)
    );

endmodule

`default_nettype wire
